### hw/rtl/shv2_pkg.sv
// shared types, constants and rotation tables of the 128-bit spooky hash engine
package shv2_pkg;

  localparam logic [63:0] HashK      = 64'hDEAD_BEEF_DEAD_BEEF;
  localparam int          LaneNum    = 12;
  localparam int          BufDepth   = 2 * LaneNum;
  localparam int          BlockBytes = 96;
  localparam int          LongBytes  = 192;
  localparam int          QueueDepth = 4;
  localparam int          CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] RegSeedFirst  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSeedSecond = 2'd1;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nb;
    logic        last;
  } item_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
    logic [127:0] tmp;
    tmp = {x, x} << r;
    return tmp[127:64];
  endfunction

  function automatic logic [5:0] mix_rot(input logic [3:0] i);
    logic [5:0] r;
    unique case (i)
      4'd0:    r = 6'd11;
      4'd1:    r = 6'd32;
      4'd2:    r = 6'd43;
      4'd3:    r = 6'd31;
      4'd4:    r = 6'd17;
      4'd5:    r = 6'd28;
      4'd6:    r = 6'd39;
      4'd7:    r = 6'd57;
      4'd8:    r = 6'd55;
      4'd9:    r = 6'd54;
      4'd10:   r = 6'd22;
      4'd11:   r = 6'd46;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] end_rot(input logic [3:0] i);
    logic [5:0] r;
    unique case (i)
      4'd0:    r = 6'd44;
      4'd1:    r = 6'd15;
      4'd2:    r = 6'd34;
      4'd3:    r = 6'd21;
      4'd4:    r = 6'd38;
      4'd5:    r = 6'd33;
      4'd6:    r = 6'd10;
      4'd7:    r = 6'd13;
      4'd8:    r = 6'd38;
      4'd9:    r = 6'd53;
      4'd10:   r = 6'd42;
      4'd11:   r = 6'd54;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] smix_rot(input logic [3:0] i);
    logic [5:0] r;
    unique case (i)
      4'd0:    r = 6'd50;
      4'd1:    r = 6'd52;
      4'd2:    r = 6'd30;
      4'd3:    r = 6'd41;
      4'd4:    r = 6'd54;
      4'd5:    r = 6'd48;
      4'd6:    r = 6'd38;
      4'd7:    r = 6'd37;
      4'd8:    r = 6'd62;
      4'd9:    r = 6'd34;
      4'd10:   r = 6'd5;
      4'd11:   r = 6'd36;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] send_rot(input logic [3:0] i);
    logic [5:0] r;
    unique case (i)
      4'd0:    r = 6'd15;
      4'd1:    r = 6'd52;
      4'd2:    r = 6'd26;
      4'd3:    r = 6'd51;
      4'd4:    r = 6'd28;
      4'd5:    r = 6'd9;
      4'd6:    r = 6'd47;
      4'd7:    r = 6'd54;
      4'd8:    r = 6'd32;
      4'd9:    r = 6'd25;
      4'd10:   r = 6'd63;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/spooky_hash_v2_128.sv
// 128-bit spooky hash v2 over a stream of little-endian 64-bit words, with
// two seed registers. Words enter a queue of QueueDepth beats and are taken
// by the engine at one beat per cycle while it is not mixing, finishing or
// delivering a message; each completed 96-byte block adds one round of lane
// mixing (two rounds when a message first reaches 192 bytes). The end of a
// long message runs tail folding and then three end rounds; the end of a
// short message runs one mix per 32-byte chunk, one per 16-byte half chunk,
// then the tail and end mix, plus a hand-over. The lane sequencer and the
// single read port of the word buffer set this pacing. One result per
// message waits in an output register while the next message is taken in.
module spooky_hash_v2_128 #(
  parameter int QueueDepth = shv2_pkg::QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [shv2_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]                  cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  logic [63:0]                  word_data_i,
  input  logic [3:0]                   valid_bytes_i,
  input  logic                         last_word_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [63:0]                  hash_first_o,
  output logic [63:0]                  hash_second_o
);

  logic            q_pop, q_empty;
  shv2_pkg::item_t q_item;

  shv2_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .word_data_i   (word_data_i),
    .valid_bytes_i (valid_bytes_i),
    .last_word_i   (last_word_i),
    .q_pop_i       (q_pop),
    .q_empty_o     (q_empty),
    .q_item_o      (q_item)
  );

  shv2_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .q_empty_i     (q_empty),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .empty         (empty),
    .pop           (pop),
    .hash_first_o  (hash_first_o),
    .hash_second_o (hash_second_o)
  );

endmodule

### hw/rtl/shv2_queue.sv
// small first-in first-out queue of classified message words
module shv2_queue #(
  parameter int Depth = shv2_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  shv2_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output shv2_pkg::item_t item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  shv2_pkg::item_t slot_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= item_i;
    end
  end

endmodule

### hw/rtl/shv2_front.sv
// input side: byte count clamping, tail masking and the word queue
module shv2_front #(
  parameter int QueueDepth = shv2_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [63:0]     word_data_i,
  input  logic [3:0]      valid_bytes_i,
  input  logic            last_word_i,
  input  logic            q_pop_i,
  output logic            q_empty_o,
  output shv2_pkg::item_t q_item_o
);

  shv2_pkg::item_t item;
  logic [3:0]      nb_eff;

  always_comb begin
    nb_eff = (!last_word_i || valid_bytes_i > 4'd8) ? 4'd8 : valid_bytes_i;
    item.nb   = nb_eff;
    item.last = last_word_i;
    for (int k = 0; k < 8; k++) begin
      item.data[8*k +: 8] = (4'(k) < nb_eff) ? word_data_i[8*k +: 8] : 8'd0;
    end
  end

  shv2_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .full_o  (full),
    .pop_i   (q_pop_i),
    .empty_o (q_empty_o),
    .item_o  (q_item_o)
  );

endmodule

### hw/rtl/shv2_back.sv
// hash engine: word buffer, lane mixing sequencer and result register
module shv2_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [shv2_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]                  cfg_data_i,
  input  logic                         q_empty_i,
  input  shv2_pkg::item_t              q_item_i,
  output logic                         q_pop_o,
  output logic                         empty,
  input  logic                         pop,
  output logic [63:0]                  hash_first_o,
  output logic [63:0]                  hash_second_o
);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_BMIX = 14'b00000000000010,
    S_LADD = 14'b00000000000100,
    S_END  = 14'b00000000001000,
    S_SDEC = 14'b00000000010000,
    S_SC   = 14'b00000000100000,
    S_SD   = 14'b00000001000000,
    S_SMIX = 14'b00000010000000,
    S_SA   = 14'b00000100000000,
    S_SB   = 14'b00001000000000,
    S_STC  = 14'b00010000000000,
    S_STD  = 14'b00100000000000,
    S_SEND = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } state_e;

  localparam int LN = shv2_pkg::LaneNum;

  state_e      state_q, state_d;
  logic [63:0] seed_first_q, seed_second_q;
  logic [63:0] lanes_q [LN];
  logic [63:0] lanes_d [LN];
  logic [63:0] t [LN];
  logic [63:0] mem [shv2_pkg::BufDepth];
  logic [63:0] rd_q;
  logic [4:0]  raddr_q, raddr_d, raddr_inc, waddr;
  logic        we;
  logic [63:0] wdata;
  logic [7:0]  byte_q, byte_d, sum;
  logic        long_q, long_d, last_q, last_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [1:0]  rnd_q, rnd_d;
  logic [2:0]  chunk_q, chunk_d;
  logic        half_q, half_d, phase_q, phase_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] hf_q, hf_d, hs_q, hs_d;
  logic [63:0] s0, u, blk;
  logic [3:0]  tail, used;

  assign empty         = !out_valid_q;
  assign hash_first_o  = hf_q;
  assign hash_second_o = hs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_first_q  <= '0;
      seed_second_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == shv2_pkg::RegSeedFirst) begin
        seed_first_q <= cfg_data_i;
      end
      if (cfg_idx_i == shv2_pkg::RegSeedSecond) begin
        seed_second_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    lanes_d     = lanes_q;
    t           = lanes_q;
    raddr_d     = raddr_q;
    raddr_inc   = (raddr_q == 5'(shv2_pkg::BufDepth - 1)) ? raddr_q : raddr_q + 5'd1;
    byte_d      = byte_q;
    long_d      = long_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    rnd_d       = rnd_q;
    chunk_d     = chunk_q;
    half_d      = half_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    hf_d        = hf_q;
    hs_d        = hs_q;
    q_pop_o     = 1'b0;
    we          = 1'b0;
    waddr       = byte_q[7:3];
    wdata       = q_item_i.data;
    sum         = byte_q + {4'd0, q_item_i.nb};
    tail        = byte_q[3:0];
    used        = 4'((byte_q + 8'd7) >> 3);
    s0          = '0;
    u           = '0;
    blk         = '0;

    if (out_valid_q && pop) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          last_d  = q_item_i.last;
          raddr_d = '0;
          cnt_d   = '0;
          we      = (q_item_i.nb != 4'd0);
          if (we && !long_q && sum >= 8'(shv2_pkg::LongBytes)) begin
            long_d = 1'b1;
            byte_d = '0;
            rnd_d  = 2'd1;
            for (int j = 0; j < LN; j++) begin
              lanes_d[j] = (j % 3 == 0) ? seed_first_q :
                           (j % 3 == 1) ? seed_second_q : shv2_pkg::HashK;
            end
            state_d = S_BMIX;
          end else if (we && long_q && sum == 8'(shv2_pkg::BlockBytes)) begin
            byte_d  = '0;
            rnd_d   = 2'd0;
            state_d = S_BMIX;
          end else begin
            byte_d = sum;
            if (q_item_i.last) begin
              if (long_q) begin
                state_d = S_LADD;
              end else begin
                chunk_d    = sum[7:5];
                half_d     = sum[4];
                lanes_d[0] = seed_first_q;
                lanes_d[1] = seed_second_q;
                lanes_d[2] = shv2_pkg::HashK;
                lanes_d[3] = shv2_pkg::HashK;
                state_d    = S_SDEC;
              end
            end
          end
        end
      end
      S_BMIX: begin
        s0     = lanes_q[0] + rd_q;
        t[2]   = lanes_q[2] ^ lanes_q[10];
        t[11]  = (lanes_q[11] ^ s0) + lanes_q[1];
        t[0]   = shv2_pkg::rotl64(s0, shv2_pkg::mix_rot(cnt_q));
        for (int j = 0; j < LN; j++) begin
          lanes_d[j] = t[(j == LN - 1) ? 0 : j + 1];
        end
        raddr_d = raddr_inc;
        cnt_d   = cnt_q + 4'd1;
        if (cnt_q == 4'(LN - 1)) begin
          cnt_d = '0;
          if (rnd_q == 2'd0) begin
            raddr_d = '0;
            state_d = last_q ? S_LADD : S_IDLE;
          end else begin
            rnd_d = rnd_q - 2'd1;
          end
        end
      end
      S_LADD: begin
        blk = (cnt_q < used) ? rd_q : 64'd0;
        if (cnt_q == 4'(LN - 1)) begin
          blk = {byte_q, blk[55:0]};
        end
        t[0] = lanes_q[0] + blk;
        for (int j = 0; j < LN; j++) begin
          lanes_d[j] = t[(j == LN - 1) ? 0 : j + 1];
        end
        raddr_d = raddr_inc;
        cnt_d   = cnt_q + 4'd1;
        if (cnt_q == 4'(LN - 1)) begin
          cnt_d   = '0;
          rnd_d   = 2'd2;
          state_d = S_END;
        end
      end
      S_END: begin
        t[11] = lanes_q[11] + lanes_q[1];
        t[2]  = lanes_q[2] ^ t[11];
        t[1]  = shv2_pkg::rotl64(lanes_q[1], shv2_pkg::end_rot(cnt_q));
        for (int j = 0; j < LN; j++) begin
          lanes_d[j] = t[(j == LN - 1) ? 0 : j + 1];
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(LN - 1)) begin
          cnt_d = '0;
          if (rnd_q == 2'd0) begin
            state_d = S_OUT;
          end else begin
            rnd_d = rnd_q - 2'd1;
          end
        end
      end
      S_SDEC: begin
        if (chunk_q != 3'd0) begin
          chunk_d = chunk_q - 3'd1;
          phase_d = 1'b1;
          state_d = S_SC;
        end else if (half_q) begin
          half_d  = 1'b0;
          phase_d = 1'b0;
          state_d = S_SC;
        end else begin
          state_d = S_STC;
        end
      end
      S_SC: begin
        lanes_d[2] = lanes_q[2] + rd_q;
        raddr_d    = raddr_inc;
        state_d    = S_SD;
      end
      S_SD: begin
        lanes_d[3] = lanes_q[3] + rd_q;
        raddr_d    = raddr_inc;
        cnt_d      = '0;
        state_d    = S_SMIX;
      end
      S_SMIX: begin
        u    = shv2_pkg::rotl64(lanes_q[2], shv2_pkg::smix_rot(cnt_q)) + lanes_q[3];
        t[2] = u;
        t[0] = lanes_q[0] ^ u;
        for (int j = 0; j < 4; j++) begin
          lanes_d[j] = t[(j + 1) % 4];
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd11) begin
          cnt_d   = '0;
          state_d = phase_q ? S_SA : S_SDEC;
        end
      end
      S_SA: begin
        lanes_d[0] = lanes_q[0] + rd_q;
        raddr_d    = raddr_inc;
        state_d    = S_SB;
      end
      S_SB: begin
        lanes_d[1] = lanes_q[1] + rd_q;
        raddr_d    = raddr_inc;
        state_d    = S_SDEC;
      end
      S_STC: begin
        if (tail == 4'd0) begin
          lanes_d[2] = lanes_q[2] + shv2_pkg::HashK;
        end else begin
          lanes_d[2] = lanes_q[2] + rd_q;
          raddr_d    = raddr_inc;
        end
        state_d = S_STD;
      end
      S_STD: begin
        blk = (tail == 4'd0) ? shv2_pkg::HashK : (tail > 4'd8) ? rd_q : 64'd0;
        lanes_d[3] = lanes_q[3] + {byte_q, 56'd0} + blk;
        cnt_d      = '0;
        state_d    = S_SEND;
      end
      S_SEND: begin
        u    = shv2_pkg::rotl64(lanes_q[2], shv2_pkg::send_rot(cnt_q));
        t[3] = (lanes_q[3] ^ lanes_q[2]) + u;
        t[2] = u;
        for (int j = 0; j < 4; j++) begin
          lanes_d[j] = t[(j + 1) % 4];
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd10) begin
          cnt_d   = '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          hf_d        = long_q ? lanes_q[0] : lanes_q[1];
          hs_d        = long_q ? lanes_q[1] : lanes_q[2];
          byte_d      = '0;
          long_d      = 1'b0;
          last_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      raddr_q     <= '0;
      byte_q      <= '0;
      long_q      <= 1'b0;
      last_q      <= 1'b0;
      cnt_q       <= '0;
      rnd_q       <= '0;
      chunk_q     <= '0;
      half_q      <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      raddr_q     <= raddr_d;
      byte_q      <= byte_d;
      long_q      <= long_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
      rnd_q       <= rnd_d;
      chunk_q     <= chunk_d;
      half_q      <= half_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
    hf_q    <= hf_d;
    hs_q    <= hs_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= (we && waddr == raddr_d) ? wdata : mem[raddr_d];
  end

  // byte count stays inside the short range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_q <= 8'(shv2_pkg::LongBytes))
    else $error("byte count beyond short range");

  // in long mode the count is a position within one block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_q |-> byte_q < 8'(shv2_pkg::BlockBytes))
    else $error("long mode position out of block");

  // buffer reads never leave the buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    raddr_q <= 5'(shv2_pkg::BufDepth - 1))
    else $error("buffer read address out of range");

  // a delivered result clears the message state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !out_valid_q) |=> (byte_q == '0 && !long_q && out_valid_q))
    else $error("message state not cleared after result");

endmodule
